// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_HOLD(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// condition holds in the cycle after reset is seen
`define ASSERT_AFTER_RST(label, clk, rst, cond) \
  label: assert property (@(posedge clk) (rst) |=> (cond)) \
    else $error("assertion failed: after reset");

`endif

// ===== hdl/ccmp_pkg.sv =====
`default_nettype none

package ccmp_pkg;

  // register stages from input to output
  localparam int unsigned PIPE_DEPTH = 9;

  localparam logic [7:0] FULL8 = 8'hff;

  // register indexes
  localparam logic CFG_FILL_COLOR  = 1'b0;
  localparam logic CFG_DEST_FORMAT = 1'b1;

  // destination formats
  localparam logic FMT_IA    = 1'b0;
  localparam logic FMT_BGR32 = 1'b1;

  // how the final pixel is formed
  typedef enum logic [2:0] {
    OVR_NONE,
    OVR_ZERO,
    OVR_PASS,
    OVR_OPAQUE,
    OVR_NO_INT
  } ovr_t;

  typedef struct packed {
    logic [31:0] fill_color;
    logic        dest_format;
  } cfg_t;

  // context carried alongside the divide
  typedef struct packed {
    ovr_t        ovr;
    logic [7:0]  alpha;
    logic [31:0] dst;
  } ctx_t;

  typedef struct packed {
    logic [17:0] num;
    logic [7:0]  den;
    logic        sat;
    ctx_t        ctx;
  } div_in_t;

  typedef struct packed {
    logic [7:0] quo;
    logic       sat;
    ctx_t       ctx;
  } div_out_t;

  // (((x + 255) >> 8) + x) >> 8, kept to 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, x} + 17'd255;
    u = {8'd0, t[16:8]} + {1'b0, x};
    return u[15:8];
  endfunction

  // (a * b + 255) >> 8
  function automatic logic [7:0] mul2(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] p;
    p = {9'd0, a} * {9'd0, b} + 17'd255;
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/coverage_alpha_composite.sv =====
// channel   dir  payload
// s_axis    in   tdata[7:0] coverage, tdata[39:8] dest_pixel
// m_axis    out  tdata[31:0] result_pixel
// cfg       in   cfg_index 0 fill_color, 1 dest_format, cfg_data[31:0]
//
// one pixel per cycle sustained while m_tready is high; from acceptance to
// m_tvalid an item passes three arithmetic stages, a five-stage restoring
// divider (two quotient bits per stage after entry) and the output register.
// rst is synchronous: it empties the pipeline and loads the register defaults.
// each stage holds its item until the next one frees, so a stall at m_tready
// fills empty stages before s_tready drops.
`default_nettype none

module coverage_alpha_composite (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // coverage [7:0], dest_pixel [39:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // result_pixel [31:0]
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ccmp_pkg::*;

  cfg_t      cfg;
  logic      f_valid, f_ready;
  div_in_t   f_data;
  logic      d_valid, d_ready;
  div_out_t  d_data;
  logic [3:0] inflight;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_color  <= 32'hffff_ffff;
      cfg.dest_format <= FMT_BGR32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FILL_COLOR:  cfg.fill_color  <= cfg_data;
        CFG_DEST_FORMAT: cfg.dest_format <= cfg_data[0];
        default:         cfg.fill_color  <= cfg.fill_color;
      endcase
    end
  end

  ccmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cov    (s_tdata[7:0]),
    .in_dst    (s_tdata[39:8]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  ccmp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  ccmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata)
  );

  // items inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 4'd0;
    end else begin
      inflight <= inflight + {3'd0, s_tvalid && s_tready}
                           - {3'd0, m_tvalid && m_tready};
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_out_has_item, clk, rst, m_tvalid, inflight != 4'd0)
  `ASSERT_HOLD(a_depth_bound, clk, rst, inflight <= 4'(PIPE_DEPTH))
  `ASSERT_IMPL(a_ready_flows, clk, rst, m_tready, s_tready)
  `ASSERT_AFTER_RST(a_reset_empty, clk, rst, !m_tvalid)

endmodule

`default_nettype wire

// ===== hdl/ccmp_front.sv =====
`default_nettype none

module ccmp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ccmp_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_cov,
  input  wire logic [31:0]       in_dst,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ccmp_pkg::div_in_t      out_data
);
  import ccmp_pkg::*;

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [7:0]  cov1, cov2, cov3;
  logic [31:0] dst1, dst2, dst3;
  logic [7:0]  s2, s3;
  logic [15:0] dipa2;
  logic [7:0]  alpha3;
  logic [9:0]  sum3;

  logic [7:0]  ca;
  logic [7:0]  s_next;
  logic [15:0] dipa_next;
  logic [7:0]  t2;
  logic [7:0]  fa_bgr;
  logic [8:0]  a_sum;
  logic [7:0]  alpha_next;
  logic [7:0]  m2;
  logic [24:0] p3;
  logic [9:0]  sum_next;
  logic [17:0] num;
  logic [7:0]  den;

  assign ca = cfg.fill_color[31:24];

  // ready chain
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1 to 2: source alpha or source weight, dest intensity times alpha
  always_comb begin
    if (cfg.dest_format == FMT_BGR32) begin
      s_next = div255({8'd0, cov1} * {8'd0, ca});
    end else if (ca == FULL8) begin
      s_next = cov1;
    end else begin
      s_next = mul2(ca, cov1);
    end
    dipa_next = {8'd0, dst1[7:0]} * {8'd0, dst1[15:8]};
  end

  // stage 2 to 3: final alpha and intensity numerator
  always_comb begin
    t2     = FULL8 - s2;
    fa_bgr = s2 + div255({8'd0, t2} * {8'd0, dst2[31:24]});
    a_sum  = {1'b0, s2} + {1'b0, mul2(dst2[15:8], t2)};
    if (cfg.dest_format == FMT_BGR32) begin
      alpha_next = fa_bgr;
    end else if (a_sum[8]) begin
      alpha_next = FULL8;
    end else begin
      alpha_next = a_sum[7:0];
    end
    m2       = mul2(cfg.fill_color[7:0], s2);
    p3       = {9'd0, dipa2} * {17'd0, t2} + 25'd65535;
    sum_next = {2'd0, m2} + {1'b0, p3[24:16]};
  end

  // stage 3 out: dividend, divisor, saturation check and special cases
  always_comb begin
    if (cfg.dest_format == FMT_BGR32) begin
      num = {2'd0, s3, 8'd0} - {10'd0, s3};
    end else begin
      num = {sum3, 8'd0} - {8'd0, sum3};
    end
    den = (alpha3 == 8'd0) ? 8'd1 : alpha3;
    out_data.num       = num;
    out_data.den       = den;
    out_data.sat       = num >= {2'd0, den, 8'd0};
    out_data.ctx.alpha = alpha3;
    out_data.ctx.dst   = dst3;
    if (cfg.dest_format == FMT_BGR32) begin
      out_data.ctx.ovr = (alpha3 == 8'd0) ? OVR_ZERO : OVR_NONE;
    end else begin
      priority if (cov3 == 8'd0) begin
        out_data.ctx.ovr = OVR_PASS;
      end else if (ca == FULL8 && cov3 == FULL8) begin
        out_data.ctx.ovr = OVR_OPAQUE;
      end else if (alpha3 == 8'd0) begin
        out_data.ctx.ovr = OVR_NO_INT;
      end else begin
        out_data.ctx.ovr = OVR_NONE;
      end
    end
  end

  assign out_valid = v3;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy1) begin
      cov1 <= in_cov;
      dst1 <= in_dst;
    end
    if (rdy2) begin
      cov2  <= cov1;
      dst2  <= dst1;
      s2    <= s_next;
      dipa2 <= dipa_next;
    end
    if (rdy3) begin
      cov3   <= cov2;
      dst3   <= dst2;
      s3     <= s2;
      alpha3 <= alpha_next;
      sum3   <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccmp_divider.sv =====
`default_nettype none

module ccmp_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ccmp_pkg::div_in_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ccmp_pkg::div_out_t     out_data
);
  import ccmp_pkg::*;

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;
  logic [17:0]       rem [STAGES];
  logic [7:0]        den [STAGES];
  logic [7:0]        quo [STAGES];
  logic              sat [STAGES];
  ctx_t              ctx [STAGES];

  // ready chain
  assign adv[STAGES-1] = !vld[STAGES-1] || out_ready;
  for (genvar j = 0; j < STAGES - 1; j++) begin : g_adv
    assign adv[j] = !vld[j] || adv[j+1];
  end
  assign in_ready = adv[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0] <= in_data.num;
      den[0] <= in_data.den;
      quo[0] <= 8'd0;
      sat[0] <= in_data.sat;
      ctx[0] <= in_data.ctx;
    end
  end

  // two quotient bits per stage, most significant first
  for (genvar j = 1; j < STAGES; j++) begin : g_step
    localparam int unsigned HI = 9 - 2 * j;
    logic [17:0] d_hi;
    logic [17:0] d_lo;
    logic [17:0] r_mid;
    logic [17:0] r_out;
    logic        b_hi;
    logic        b_lo;

    always_comb begin
      d_hi  = {10'd0, den[j-1]} << HI;
      d_lo  = {10'd0, den[j-1]} << (HI - 1);
      b_hi  = rem[j-1] >= d_hi;
      r_mid = b_hi ? rem[j-1] - d_hi : rem[j-1];
      b_lo  = r_mid >= d_lo;
      r_out = b_lo ? r_mid - d_lo : r_mid;
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem[j] <= r_out;
        den[j] <= den[j-1];
        quo[j] <= {quo[j-1][5:0], b_hi, b_lo};
        sat[j] <= sat[j-1];
        ctx[j] <= ctx[j-1];
      end
    end
  end

  assign out_valid    = vld[STAGES-1];
  assign out_data.quo = quo[STAGES-1];
  assign out_data.sat = sat[STAGES-1];
  assign out_data.ctx = ctx[STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/ccmp_back.sv =====
`default_nettype none

module ccmp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ccmp_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ccmp_pkg::div_out_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_pixel
);
  import ccmp_pkg::*;

  logic [7:0]  q;
  logic [7:0]  wd;
  logic [7:0]  ch_r, ch_g, ch_b;
  logic [7:0]  inten;
  logic [31:0] dst;
  logic [31:0] pixel_next;

  // source weight times colour plus dest weight times pixel, over 255
  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] d,
                                     input logic [7:0] ws, input logic [7:0] wdst);
    logic [16:0] acc;
    acc = {9'd0, c} * {9'd0, ws} + {9'd0, d} * {9'd0, wdst};
    return div255(acc[15:0]);
  endfunction

  assign in_ready = !out_valid || out_ready;

  // channel lanes
  always_comb begin
    q     = in_data.quo;
    wd    = FULL8 - q;
    dst   = in_data.ctx.dst;
    ch_r  = mix(cfg.fill_color[7:0], dst[7:0], q, wd);
    ch_g  = mix(cfg.fill_color[15:8], dst[15:8], q, wd);
    ch_b  = mix(cfg.fill_color[23:16], dst[23:16], q, wd);
    inten = in_data.sat ? FULL8 : q;
  end

  // result selection
  always_comb begin
    if (cfg.dest_format == FMT_BGR32) begin
      if (in_data.ctx.ovr == OVR_ZERO) begin
        pixel_next = 32'd0;
      end else begin
        pixel_next = {in_data.ctx.alpha, ch_b, ch_g, ch_r};
      end
    end else begin
      unique case (in_data.ctx.ovr)
        OVR_PASS:   pixel_next = dst;
        OVR_OPAQUE: pixel_next = {dst[31:16], FULL8, cfg.fill_color[7:0]};
        OVR_NO_INT: pixel_next = {dst[31:16], in_data.ctx.alpha, 8'd0};
        default:    pixel_next = {dst[31:16], in_data.ctx.alpha, inten};
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire
